// ----- src/modexp_pkg.sv -----
// Shared types for the modular exponentiation unit.
package modexp_pkg;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_ACCUM,
      OP_DOUBLE
   } op_type;

endpackage

// ----- src/modexp_modadd.sv -----
// Shared modular adder: operand select, wide add with carry-in and conditional subtract.
module modexp_modadd #(
   parameter int WIDTH = 63
) (
   input  modexp_pkg::op_type op,
   input  logic [WIDTH-1:0]   modulus,
   input  logic [WIDTH-1:0]   sq_value,
   input  logic [WIDTH-1:0]   mul_acc,
   input  logic [WIDTH-1:0]   addend,
   input  logic               carry,
   output logic [WIDTH-1:0]   result
);

   logic [WIDTH-1:0] opa;
   logic [WIDTH-1:0] opb;
   logic             cin;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   diff;

   always_comb begin
      unique case (op)
         modexp_pkg::OP_REDUCE: begin
            opa = sq_value;
            opb = sq_value;
            cin = carry;
         end
         modexp_pkg::OP_ACCUM: begin
            opa = mul_acc;
            opb = addend;
            cin = 1'b0;
         end
         modexp_pkg::OP_DOUBLE: begin
            opa = addend;
            opb = addend;
            cin = 1'b0;
         end
         default: begin
            opa = '0;
            opb = '0;
            cin = 1'b0;
         end
      endcase
   end

   // both operands below the modulus, so one subtraction reduces the sum
   assign sum    = {1'b0, opa} + {1'b0, opb} + {{WIDTH{1'b0}}, cin};
   assign diff   = sum - {1'b0, modulus};
   assign result = (sum >= {1'b0, modulus}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

// ----- src/modular_exponentiation_unit.sv -----
// Modular exponentiation top level: sequencer, operand registers and configuration register.
// Computes req_base_value ^ req_exponent mod csr modulus, one request at a time. A request is
// taken when start is high and busy is low; busy stays high until the result has been shown.
// The result appears on rsp_power_result for exactly one cycle with rsp_valid high and must be
// captured then, as the receiver cannot stall the block. All arithmetic runs through a single
// modular adder, one add per cycle: the base is first reduced bit by bit, MSB first, then each
// modular product takes a setup step, a doubling step per multiplier bit below its highest set
// bit, an accumulate step per set bit and a final step, so latency is data dependent. A zero
// modulus returns 0 in the cycle right after the request is taken.
// The modulus may be written only while busy is low; it resets to 1.
module modular_exponentiation_unit #(
   parameter int WIDTH = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_base_value,
   input  logic [WIDTH-1:0] req_exponent,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_power_result,
   input  logic             csr_write_enable,
   input  logic [WIDTH-1:0] csr_write_data
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_EXP,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [WIDTH-1:0]   mod_ff, mod_in;
   logic [WIDTH-1:0]   base_ff, base_in;
   logic [WIDTH-1:0]   exp_ff, exp_in;
   logic [WIDTH-1:0]   acc_ff, acc_in;
   logic [WIDTH-1:0]   sq_ff, sq_in;
   logic [WIDTH-1:0]   mul_acc_ff, mul_acc_in;
   logic [WIDTH-1:0]   addend_ff, addend_in;
   logic [WIDTH-1:0]   mult_ff, mult_in;
   logic               square_ff, square_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   modexp_pkg::op_type op;
   logic [WIDTH-1:0]   unit_result;

   modexp_modadd #(
      .WIDTH(WIDTH)
   ) u_modadd (
      .op      (op),
      .modulus (mod_ff),
      .sq_value(sq_ff),
      .mul_acc (mul_acc_ff),
      .addend  (addend_ff),
      .carry   (base_ff[WIDTH-1]),
      .result  (unit_result)
   );

   always_comb begin
      if (state_ff == ST_REDUCE) begin
         op = modexp_pkg::OP_REDUCE;
      end else if (mult_ff[0]) begin
         op = modexp_pkg::OP_ACCUM;
      end else begin
         op = modexp_pkg::OP_DOUBLE;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mod_in     = mod_ff;
      base_in    = base_ff;
      exp_in     = exp_ff;
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      mul_acc_in = mul_acc_ff;
      addend_in  = addend_ff;
      mult_in    = mult_ff;
      square_in  = square_ff;
      cnt_in     = cnt_ff;

      if (csr_write_enable) begin
         mod_in = csr_write_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mod_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  acc_in   = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
                  base_in  = req_base_value;
                  exp_in   = req_exponent;
                  sq_in    = '0;
                  cnt_in   = CNT_W'(WIDTH);
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            // base mod m, MSB first: r = 2r + bit, one conditional subtract
            sq_in   = unit_result;
            base_in = {base_ff[WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               mul_acc_in = '0;
               addend_in  = acc_ff;
               mult_in    = sq_ff;
               square_in  = 1'b0;
               exp_in     = {exp_ff[WIDTH-1:1], 1'b0};
               state_in   = ST_MUL;
            end else begin
               mul_acc_in = '0;
               addend_in  = sq_ff;
               mult_in    = sq_ff;
               square_in  = 1'b1;
               exp_in     = {1'b0, exp_ff[WIDTH-1:1]};
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mult_ff == '0) begin
               if (square_ff) begin
                  sq_in = mul_acc_ff;
               end else begin
                  acc_in = mul_acc_ff;
               end
               state_in = ST_EXP;
            end else if (mult_ff[0]) begin
               mul_acc_in = unit_result;
               mult_in    = {mult_ff[WIDTH-1:1], 1'b0};
            end else begin
               addend_in = unit_result;
               mult_in   = {1'b0, mult_ff[WIDTH-1:1]};
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff   <= WIDTH'(1);
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
      end
      base_ff    <= base_in;
      exp_ff     <= exp_in;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      mul_acc_ff <= mul_acc_in;
      addend_ff  <= addend_in;
      mult_ff    <= mult_in;
      square_ff  <= square_in;
      cnt_ff     <= cnt_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_power_result = acc_ff;

endmodule

// ----- verif/tb_modular_exponentiation_unit.sv -----
// Testbench for the modular exponentiation unit: directed table plus random requests.
module tb_modular_exponentiation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = 63;
   localparam int unsigned STALL_LIMIT = 100000;
   localparam int N_DIRECTED = 25;
   localparam int N_PHASES = 9;
   localparam int PHASE_REQUESTS = 9;
   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] BIT62 = 63'h4000_0000_0000_0000;
   localparam logic [W-1:0] BIT61 = 63'h2000_0000_0000_0000;

   typedef enum bit {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [W-1:0] a;
      logic [W-1:0] b;
      bit           typed;
      logic [W-1:0] want;
   } vector_type;

   typedef struct {
      int unsigned  id;
      logic [W-1:0] power;
   } pending_power_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [W-1:0] req_base_value = '0;
   logic [W-1:0] req_exponent = '0;
   logic         rsp_valid;
   logic [W-1:0] rsp_power_result;
   logic         csr_write_enable = 1'b0;
   logic [W-1:0] csr_write_data = '0;

   pending_power_type power_q[$];
   logic [W-1:0]      modulus_model = W'(1);
   int unsigned       request_count = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       stall_cycles = 0;
   bit                quiet = 1'b0;

   // request rows: base, exponent; csr rows: modulus in a
   vector_type directed_tbl [N_DIRECTED] = '{
      '{ROW_REQUEST, 63'd5, 63'd0, 1'b1, 63'd0},
      '{ROW_REQUEST, ALL_ONES, ALL_ONES, 1'b1, 63'd0},
      '{ROW_CSR, 63'd0, 63'd0, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd7, 63'd9, 1'b1, 63'd0},
      '{ROW_REQUEST, ALL_ONES, ALL_ONES, 1'b1, 63'd0},
      '{ROW_CSR, ALL_ONES, 63'd0, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd0, 63'd0, 1'b1, 63'd1},
      '{ROW_REQUEST, ALL_ONES, 63'd5, 1'b1, 63'd0},
      '{ROW_REQUEST, 63'd2, 63'd1, 1'b1, 63'd2},
      '{ROW_REQUEST, ALL_ONES - 63'd1, 63'd1, 1'b1, ALL_ONES - 63'd1},
      '{ROW_REQUEST, ALL_ONES - 63'd1, 63'd2, 1'b1, 63'd1},
      '{ROW_REQUEST, ALL_ONES - 63'd1, ALL_ONES, 1'b1, ALL_ONES - 63'd1},
      '{ROW_REQUEST, 63'h5555_5555_5555_5555, ALL_ONES, 1'b0, 63'd0},
      '{ROW_CSR, 63'd2, 63'd0, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd3, 63'd0, 1'b1, 63'd1},
      '{ROW_REQUEST, 63'd4, 63'd7, 1'b1, 63'd0},
      '{ROW_REQUEST, ALL_ONES, ALL_ONES, 1'b1, 63'd1},
      '{ROW_CSR, 63'd1000000007, 63'd0, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd2, 63'd1000000006, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd123456789, 63'd987654321, 1'b0, 63'd0},
      '{ROW_CSR, BIT62, 63'd0, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd2, 63'd62, 1'b1, 63'd0},
      '{ROW_REQUEST, 63'd2, 63'd61, 1'b1, BIT61},
      '{ROW_REQUEST, 63'd3, ALL_ONES, 1'b0, 63'd0},
      '{ROW_REQUEST, 63'd0, 63'd0, 1'b1, 63'd1}
   };

   modular_exponentiation_unit #(.WIDTH(W)) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_base_value  (req_base_value),
      .req_exponent    (req_exponent),
      .rsp_valid       (rsp_valid),
      .rsp_power_result(rsp_power_result),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [W-1:0] mod_sum(input logic [W-1:0] x, y, m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] mod_product(input logic [W-1:0] x, y, m);
      logic [W-1:0] acc;
      logic [W-1:0] addend;
      acc = '0;
      addend = x;
      for (int i = 0; i < W; i++) begin
         if (y[i]) begin
            acc = mod_sum(acc, addend, m);
         end
         addend = mod_sum(addend, addend, m);
      end
      return acc;
   endfunction

   function automatic logic [W-1:0] predict_power(input logic [W-1:0] b, e, m);
      logic [W-1:0] acc;
      logic [W-1:0] sq;
      if (m == '0) begin
         return '0;
      end
      acc = (m == W'(1)) ? '0 : W'(1);
      sq = b % m;
      for (int i = 0; i < W; i++) begin
         if (e[i]) begin
            acc = mod_product(acc, sq, m);
         end
         sq = mod_product(sq, sq, m);
      end
      return acc;
   endfunction

   function automatic logic [W-1:0] rand63();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[W-1:0];
   endfunction

   function automatic logic [W-1:0] pick_modulus();
      logic [W-1:0] m;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: m = W'($urandom_range(2, 255));
         4, 5: m = rand63() & 63'hFFFF;
         6: m = rand63() & 63'hFFFF_FFFF;
         7: m = rand63() & 63'hFFFF_FFFF_FFFF;
         8: m = rand63();
         default: begin
            case ($urandom_range(0, 2))
               0: m = W'(1);
               1: m = W'(2);
               default: m = ALL_ONES;
            endcase
         end
      endcase
      return m;
   endfunction

   function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return m - W'(1);
         2: return m;
         3: return ALL_ONES;
         default: return rand63();
      endcase
   endfunction

   function automatic logic [W-1:0] pick_exponent();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return W'($urandom_range(1, 3));
         2: return ALL_ONES;
         3: return BIT62 >> $urandom_range(0, 62);
         default: return rand63();
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // lower start, then hold until no result is outstanding and the unit is idle
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (power_q.size() != 0 || busy);
   endtask

   task automatic program_modulus(input logic [W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      modulus_model = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic issue(input logic [W-1:0] b, e, input bit typed, input logic [W-1:0] want);
      int unsigned       gap;
      pending_power_type entry;
      gap = 0;
      if (!quiet && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 14);
      end
      if (gap != 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_base_value <= b;
      req_exponent <= e;
      do @(posedge clock); while (busy);
      entry.id = request_count;
      entry.power = typed ? want : predict_power(b, e, modulus_model);
      power_q.push_back(entry);
      request_count++;
   endtask

   always @(posedge clock) begin
      pending_power_type head;
      if (!reset && rsp_valid) begin
         if (power_q.size() == 0) begin
            report_mismatch($sformatf("result %0h with no request pending", rsp_power_result));
         end else begin
            head = power_q.pop_front();
            if (rsp_power_result !== head.power) begin
               report_mismatch($sformatf("request %0d power_result %0h, want %0h",
                                         head.id, rsp_power_result, head.power));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("modular_exponentiation_unit regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [W-1:0] m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      modulus_model = W'(1);

      foreach (directed_tbl[i]) begin
         if (directed_tbl[i].kind == ROW_CSR) begin
            program_modulus(directed_tbl[i].a);
         end else begin
            issue(directed_tbl[i].a, directed_tbl[i].b, directed_tbl[i].typed,
                  directed_tbl[i].want);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         quiet = (p == N_PHASES - 1);
         m = pick_modulus();
         program_modulus(m);
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            if (p == 2 && k == 5) begin
               wait_idle();
            end
            issue(pick_base(m), pick_exponent(), 1'b0, '0);
         end
      end

      wait_idle();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("modular_exponentiation_unit regression: pass");
      end else begin
         $display("modular_exponentiation_unit regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/modexp_pkg.sv
src/modexp_modadd.sv
src/modular_exponentiation_unit.sv
verif/tb_modular_exponentiation_unit.sv
